FILE: rtl/dpt_pkg.sv
// Shared types, codes and the transition table for the disc player transport block.
`timescale 1ns / 1ps

package dpt_pkg;

    // Player states; code 7 is never produced
    typedef enum logic [2:0] {
        ST_OFF      = 3'd0,
        ST_NO_DISC  = 3'd1,
        ST_LOADING  = 3'd2,
        ST_EJECTING = 3'd3,
        ST_STOP     = 3'd4,
        ST_PLAY     = 3'd5,
        ST_PAUSE    = 3'd6
    } player_state_t;

    // Transport events
    typedef enum logic [2:0] {
        EV_POWER_ON   = 3'd0,
        EV_POWER_OFF  = 3'd1,
        EV_DISC_KEY   = 3'd2,
        EV_DISC_DONE  = 3'd3,
        EV_PLAY_PAUSE = 3'd4,
        EV_PREV       = 3'd5,
        EV_NEXT       = 3'd6,
        EV_RELEASE    = 3'd7
    } event_t;

    // Item kinds
    localparam logic OP_EVENT  = 1'b0;
    localparam logic OP_REPEAT = 1'b1;

    // Repeat direction codes
    localparam logic [1:0] REPEAT_NONE = 2'd0;
    localparam logic [1:0] REPEAT_PREV = 2'd1;
    localparam logic [1:0] REPEAT_NEXT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TRACK_FIRST = 1'b0;
    localparam logic CFG_TRACK_LAST  = 1'b1;

    // Reset values
    localparam logic [7:0] TRACK_FIRST_RESET = 8'd1;
    localparam logic [7:0] TRACK_LAST_RESET  = 8'd99;

    typedef struct packed {
        logic       operation;
        logic [2:0] event_code;
    } in_item_t;

    typedef struct packed {
        logic [2:0] player_state;
        logic [7:0] track_number;
        logic       disc_action_pending;
        logic [1:0] repeat_direction;
    } out_item_t;

    // Track limits from the configuration registers
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] last;
    } track_limits_t;

    // Architectural state of the player
    typedef struct packed {
        player_state_t current;
        player_state_t remembered;
        logic [7:0]    track;
        logic          pending;
        logic [1:0]    repeat_code;
    } player_ctx_t;

    // Fixed next-state table
    function automatic player_state_t next_state(player_state_t st, event_t ev);
        player_state_t nxt;
        nxt = st;
        unique case (st)
            ST_OFF:
            begin
                if (ev == EV_POWER_ON)
                    nxt = ST_STOP;
            end
            ST_NO_DISC:
            begin
                if (ev == EV_POWER_OFF)
                    nxt = ST_OFF;
                else if (ev == EV_DISC_KEY)
                    nxt = ST_LOADING;
            end
            ST_LOADING:
            begin
                if (ev == EV_POWER_OFF)
                    nxt = ST_OFF;
                else if (ev == EV_DISC_DONE)
                    nxt = ST_STOP;
            end
            ST_EJECTING:
            begin
                if (ev == EV_POWER_OFF)
                    nxt = ST_OFF;
                else if (ev == EV_DISC_DONE)
                    nxt = ST_NO_DISC;
            end
            ST_STOP:
            begin
                if (ev == EV_POWER_OFF)
                    nxt = ST_OFF;
                else if (ev == EV_DISC_KEY)
                    nxt = ST_EJECTING;
                else if (ev == EV_PLAY_PAUSE)
                    nxt = ST_PLAY;
            end
            ST_PLAY:
            begin
                if (ev == EV_POWER_OFF)
                    nxt = ST_OFF;
                else if (ev == EV_DISC_KEY)
                    nxt = ST_EJECTING;
                else if (ev == EV_PLAY_PAUSE)
                    nxt = ST_PAUSE;
            end
            ST_PAUSE:
            begin
                if (ev == EV_POWER_OFF)
                    nxt = ST_OFF;
                else if (ev == EV_DISC_KEY)
                    nxt = ST_EJECTING;
                else if (ev == EV_PLAY_PAUSE)
                    nxt = ST_PLAY;
            end
            default:
            begin
                nxt = st;
            end
        endcase
        return nxt;
    endfunction

    function automatic logic is_transient(player_state_t st);
        return (st == ST_OFF) || (st == ST_LOADING) || (st == ST_EJECTING);
    endfunction

endpackage

FILE: rtl/dpt_cfg.sv
// Track limit configuration registers.
`timescale 1ns / 1ps

module dpt_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data,
    output dpt_pkg::track_limits_t limits
);
    import dpt_pkg::*;

    logic [7:0] first_reg;
    logic [7:0] last_reg;

    // Write the addressed limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= TRACK_FIRST_RESET;
            last_reg  <= TRACK_LAST_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TRACK_FIRST: first_reg <= cfg_data;
                CFG_TRACK_LAST:  last_reg  <= cfg_data;
                default:         first_reg <= first_reg;
            endcase
        end
    end

    assign limits.first = first_reg;
    assign limits.last  = last_reg;

endmodule

FILE: rtl/dpt_step.sv
// Transition logic: next player context for one transaction.
`timescale 1ns / 1ps

module dpt_step (
    input  dpt_pkg::player_ctx_t   ctx,
    input  dpt_pkg::track_limits_t limits,
    input  dpt_pkg::in_item_t      item,
    output dpt_pkg::player_ctx_t   ctx_next
);
    import dpt_pkg::*;

    event_t        ev;
    player_state_t old;
    player_state_t restored;
    logic          playing;
    logic          valid_state;

    assign ev          = event_t'(item.event_code);
    assign old         = ctx.current;
    assign playing     = (old == ST_PLAY) || (old == ST_PAUSE);
    assign valid_state = (old != player_state_t'(3'd7));
    assign restored    = is_transient(ctx.remembered) ? ST_STOP : ctx.remembered;

    // Apply the table lookup and the side action of the event, or set the repeat direction for a repeat item
    always_comb
    begin
        ctx_next = ctx;
        if (item.operation == OP_REPEAT)
        begin
            case (ev)
                EV_PREV: ctx_next.repeat_code = REPEAT_PREV;
                EV_NEXT: ctx_next.repeat_code = REPEAT_NEXT;
                default: ctx_next.repeat_code = REPEAT_NONE;
            endcase
        end
        else if (valid_state)
        begin
            ctx_next.current = next_state(old, ev);
            unique case (ev)
                EV_POWER_ON:
                begin
                    if (old == ST_OFF)
                    begin
                        ctx_next.remembered  = restored;
                        ctx_next.current     = restored;
                        ctx_next.pending     = 1'b0;
                        ctx_next.repeat_code = REPEAT_NONE;
                    end
                end
                EV_POWER_OFF:
                begin
                    if (old != ST_OFF)
                    begin
                        if (!is_transient(old))
                            ctx_next.remembered = old;
                        ctx_next.pending     = 1'b0;
                        ctx_next.repeat_code = REPEAT_NONE;
                    end
                end
                EV_DISC_KEY:
                begin
                    if (old == ST_NO_DISC || old == ST_STOP || playing)
                    begin
                        ctx_next.pending     = 1'b1;
                        ctx_next.repeat_code = REPEAT_NONE;
                    end
                end
                EV_DISC_DONE:
                begin
                    if (old == ST_LOADING || old == ST_EJECTING)
                    begin
                        ctx_next.pending = 1'b0;
                        ctx_next.track   = limits.first;
                    end
                end
                EV_PLAY_PAUSE:
                begin
                    if (old == ST_STOP || playing)
                        ctx_next.repeat_code = REPEAT_NONE;
                end
                EV_PREV:
                begin
                    // Step back, wrap to the last track
                    if (playing)
                        ctx_next.track = (ctx.track <= limits.first) ?
                                         limits.last : ctx.track - 8'd1;
                end
                EV_NEXT:
                begin
                    // Step forward, wrap to the first track
                    if (playing)
                        ctx_next.track = (ctx.track >= limits.last) ?
                                         limits.first : ctx.track + 8'd1;
                end
                default:
                begin
                    ctx_next.current = next_state(old, ev);
                end
            endcase
        end
    end

endmodule

FILE: rtl/disc_player_transport_fsm.sv
// Top level of the disc player transport state machine.
`timescale 1ns / 1ps

// Disc player transport control. Each input transaction is either a
// transport event or a repeat-direction setting and yields exactly one
// result: player state, track number, pending disc action flag and repeat
// direction as they stand after the transaction. An accepted transaction
// is held in an input register, the transition logic runs between that
// register and the result register, and the result leaves from the
// result register. One transaction is taken every cycle while the result
// side keeps up; throughput is set by the single result register, which
// stalls the input register only when a result waits unclaimed. Track
// limits are written through cfg_write/cfg_index/cfg_data and reset to 1
// and 99; the user must write them only while the block is idle, which the
// block itself does not enforce.

module disc_player_transport_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  dpt_pkg::in_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output dpt_pkg::out_item_t out_item
);
    import dpt_pkg::*;

    track_limits_t limits;
    player_ctx_t   ctx_reg;
    player_ctx_t   ctx_next;
    in_item_t      item_reg;
    logic          item_valid_reg;
    out_item_t     out_item_reg;
    logic          out_valid_reg;
    logic          advance;

    dpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    dpt_step u_step (
        .ctx      (ctx_reg),
        .limits   (limits),
        .item     (item_reg),
        .ctx_next (ctx_next)
    );

    // Move the held transaction into the result register when it is free or its result is being taken
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_item;
    end

    // Player context: advance on each transaction that moves to the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.current     <= ST_OFF;
            ctx_reg.remembered  <= ST_STOP;
            ctx_reg.track       <= TRACK_FIRST_RESET;
            ctx_reg.pending     <= 1'b0;
            ctx_reg.repeat_code <= REPEAT_NONE;
        end
        else if (advance)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.player_state        <= ctx_next.current;
            out_item_reg.track_number        <= ctx_next.track;
            out_item_reg.disc_action_pending <= ctx_next.pending;
            out_item_reg.repeat_direction    <= ctx_next.repeat_code;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
